### hw/rtl/comma_separated_id_line_parser_unit_macros.svh
// assertion macros shared by the id line parser rtl
`ifndef COMMA_SEPARATED_ID_LINE_PARSER_UNIT_MACROS_SVH
`define COMMA_SEPARATED_ID_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CSIDLP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CSIDLP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/csidlp_pkg.sv
// types and constants of the comma separated id line parser
package csidlp_pkg;

    // fixed field widths
    localparam int ID_W       = 16;
    localparam int STATUS_W   = 3;
    localparam int CH_W       = 8;
    localparam int OUT_DATA_W = 24;

    // input beat kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // character codes
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_COMMA = 8'h2c;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0d;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0a;

    // parser phase
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_EXPECT = 3'd1,
        PH_DIGITS = 3'd2,
        PH_AFTER  = 3'd3,
        PH_ERROR  = 3'd4
    } t_phase;

    // line status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_TRAILING = 3'd2,
        ST_NONNUM   = 3'd3,
        ST_TOOLARGE = 3'd4,
        ST_BADCHAR  = 3'd5
    } t_status;

    // one result beat
    typedef struct packed {
        logic            id_valid;
        logic [ID_W-1:0] id;
        logic            line_done;
        t_status         status;
    } t_result;

endpackage

### hw/rtl/comma_separated_id_line_parser_unit.sv
// comma separated decimal id line parser, top level
//
// slave channel: one beat per character (tuser = 0, tdata = byte), then one
// end-of-line beat (tuser = 1, tdata ignored). ids are unsigned decimal,
// up to 2^ID_BITS - 1, separated by commas, with space, tab, cr, lf around.
// master channel: a beat with tuser = 1 carries a finished id; it is sent on
// the character that ends the digit run, or on the end-of-line beat when the
// line ends inside a run. the end-of-line beat always gives one result with
// tlast = 1 and the line status in tdata; after the first error the rest of
// the line is skipped and ids already sent for it should be dropped.
// the result of an accepted beat is registered in the head entry, or in
// the skid entry while the head waits; one beat is taken every cycle
// while s_tready is high, with the single parse step between the phase registers and the result register.
// a one-entry skid buffer behind the result register keeps s_tready high
// while a result waits; s_tready falls only when both entries are full.
// reset (synchronous, active low) returns the parser to line start and
// empties both output entries.
`include "comma_separated_id_line_parser_unit_macros.svh"

module comma_separated_id_line_parser_unit #(
    parameter int ID_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave side
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [csidlp_pkg::CH_W-1:0]         i_s_tdata,  // [7:0] ch
    input  logic                                i_s_tuser,  // [0] kind
    // master side
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [csidlp_pkg::OUT_DATA_W-1:0]   o_m_tdata,  // [15:0] id, [18:16] status
    output logic                                o_m_tuser,  // [0] id_valid
    output logic                                o_m_tlast   // line_done
);

    localparam int IdW  = csidlp_pkg::ID_W;
    localparam int PadW = csidlp_pkg::OUT_DATA_W - csidlp_pkg::ID_W - csidlp_pkg::STATUS_W;
    localparam int ProdW = ID_BITS + 4;

    // parse state
    csidlp_pkg::t_phase  r_phase, n_phase;
    logic [ID_BITS-1:0]  r_partial, n_partial;
    csidlp_pkg::t_status r_first_error, n_first_error;

    // output head and skid entries
    logic                r_out_valid, r_skid_valid;
    csidlp_pkg::t_result r_out, r_skid;

    logic                s_fire, m_fire;
    logic                is_eol, ch_blank, ch_digit, ch_comma;
    logic [csidlp_pkg::CH_W-1:0] digit_off;
    logic [3:0]          digit;
    logic [ProdW-1:0]    ext_partial, prod;
    logic                prod_ovf;
    logic [ID_BITS+IdW-1:0] id_wide;
    logic [IdW-1:0]      cur_id;
    logic                res_valid;
    csidlp_pkg::t_result res;

    assign s_fire = i_s_tvalid && o_s_tready;
    assign m_fire = r_out_valid && i_m_tready;
    assign o_s_tready = !r_skid_valid;

    // character classes
    assign is_eol    = (i_s_tuser == csidlp_pkg::KIND_EOL);
    assign ch_digit  = (i_s_tdata >= csidlp_pkg::CH_ZERO) && (i_s_tdata <= csidlp_pkg::CH_NINE);
    assign ch_comma  = (i_s_tdata == csidlp_pkg::CH_COMMA);
    assign ch_blank  = (i_s_tdata == csidlp_pkg::CH_SPACE) || (i_s_tdata == csidlp_pkg::CH_TAB)
                    || (i_s_tdata == csidlp_pkg::CH_CR) || (i_s_tdata == csidlp_pkg::CH_LF);
    assign digit_off = i_s_tdata - csidlp_pkg::CH_ZERO;
    assign digit     = digit_off[3:0];

    // partial * 10 + digit, overflow in the top four bits
    assign ext_partial = {4'b0000, r_partial};
    assign prod        = (ext_partial << 3) + (ext_partial << 1) + {{(ProdW-4){1'b0}}, digit};
    assign prod_ovf    = |prod[ProdW-1:ID_BITS];

    // id as presented on the 16-bit field
    assign id_wide = {{IdW{1'b0}}, r_partial};
    assign cur_id  = id_wide[IdW-1:0];

    // next parse state
    always_comb begin
        n_phase       = r_phase;
        n_partial     = r_partial;
        n_first_error = r_first_error;
        if (s_fire) begin
            if (is_eol) begin
                n_phase       = csidlp_pkg::PH_START;
                n_partial     = '0;
                n_first_error = csidlp_pkg::ST_OK;
            end else begin
                unique case (r_phase)
                    csidlp_pkg::PH_START, csidlp_pkg::PH_EXPECT: begin
                        if (ch_blank) begin
                            n_phase = r_phase;
                        end else if (ch_digit) begin
                            n_phase   = csidlp_pkg::PH_DIGITS;
                            n_partial = {{(ID_BITS-4){1'b0}}, digit};
                        end else begin
                            n_phase       = csidlp_pkg::PH_ERROR;
                            n_first_error = csidlp_pkg::ST_NONNUM;
                            n_partial     = '0;
                        end
                    end
                    csidlp_pkg::PH_DIGITS: begin
                        if (ch_digit) begin
                            if (prod_ovf) begin
                                n_phase       = csidlp_pkg::PH_ERROR;
                                n_first_error = csidlp_pkg::ST_TOOLARGE;
                                n_partial     = '0;
                            end else begin
                                n_partial = prod[ID_BITS-1:0];
                            end
                        end else begin
                            n_partial = '0;
                            if (ch_blank) begin
                                n_phase = csidlp_pkg::PH_AFTER;
                            end else if (ch_comma) begin
                                n_phase = csidlp_pkg::PH_EXPECT;
                            end else begin
                                n_phase       = csidlp_pkg::PH_ERROR;
                                n_first_error = csidlp_pkg::ST_BADCHAR;
                            end
                        end
                    end
                    csidlp_pkg::PH_AFTER: begin
                        if (ch_comma) begin
                            n_phase = csidlp_pkg::PH_EXPECT;
                        end else if (!ch_blank) begin
                            n_phase       = csidlp_pkg::PH_ERROR;
                            n_first_error = csidlp_pkg::ST_BADCHAR;
                            n_partial     = '0;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // result of the accepted beat
    always_comb begin
        res_valid     = 1'b0;
        res.id_valid  = 1'b0;
        res.id        = '0;
        res.line_done = 1'b0;
        res.status    = csidlp_pkg::ST_OK;
        if (s_fire) begin
            if (is_eol) begin
                res_valid     = 1'b1;
                res.line_done = 1'b1;
                unique case (r_phase)
                    csidlp_pkg::PH_START:  res.status = csidlp_pkg::ST_EMPTY;
                    csidlp_pkg::PH_EXPECT: res.status = csidlp_pkg::ST_TRAILING;
                    csidlp_pkg::PH_DIGITS: begin
                        res.id_valid = 1'b1;
                        res.id       = cur_id;
                    end
                    csidlp_pkg::PH_AFTER:  res.status = csidlp_pkg::ST_OK;
                    default:               res.status = r_first_error;
                endcase
            end else if ((r_phase == csidlp_pkg::PH_DIGITS) && !ch_digit) begin
                res_valid    = 1'b1;
                res.id_valid = 1'b1;
                res.id       = cur_id;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= csidlp_pkg::PH_START;
            r_partial     <= '0;
            r_first_error <= csidlp_pkg::ST_OK;
        end else begin
            r_phase       <= n_phase;
            r_partial     <= n_partial;
            r_first_error <= n_first_error;
        end
    end

    // output head and skid control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || m_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (m_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_fire) begin
                r_out <= r_skid;
            end
        end else if (res_valid) begin
            if (!r_out_valid || m_fire) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    // master side beat
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{PadW{1'b0}}, r_out.status, r_out.id};
    assign o_m_tuser  = r_out.id_valid;
    assign o_m_tlast  = r_out.line_done;

    // checks
    `CSIDLP_ASSERT_IMP(a_skid_needs_head, r_skid_valid, r_out_valid, "skid entry without head entry")
    `CSIDLP_ASSERT_NXT(a_eol_restarts, s_fire && is_eol, r_phase == csidlp_pkg::PH_START, "phase not back to line start after end of line")
    `CSIDLP_ASSERT_IMP(a_error_only_in_error, r_phase != csidlp_pkg::PH_ERROR, r_first_error == csidlp_pkg::ST_OK, "error code held outside error phase")
    `CSIDLP_ASSERT_IMP(a_status_on_eol_only, r_out_valid && !r_out.line_done, r_out.status == csidlp_pkg::ST_OK, "status on a beat that is not end of line")

endmodule

### test/tb.sv
// testbench for the comma separated id line parser: directed table, random lines, scoreboard
module tb;
    import csidlp_pkg::*;

    localparam int DIR_N       = 29;
    localparam int RAND_ITEMS  = 1700;
    localparam int TAIL_N      = 150;
    localparam int QUIET_LIMIT = 1000;
    localparam logic [19:0] ID_LIMIT = (20'd1 << ID_W) - 20'd1;

    // one slave beat, with an optional expectation typed in by hand
    typedef struct packed {
        logic            kind;
        logic [CH_W-1:0] ch;
        logic            typed;
        t_result         want;
    } t_beat;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [CH_W-1:0]       i_s_tdata;   // [7:0] ch
    logic                  i_s_tuser;   // [0] kind
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // [15:0] id, [18:16] status
    logic                  o_m_tuser;   // [0] id_valid
    logic                  o_m_tlast;   // line_done

    comma_separated_id_line_parser_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // predicted parser state
    t_phase      ln_phase;
    logic [15:0] run_value;
    t_status     latched_err;

    t_beat       dir_tab [DIR_N];
    t_beat       line_beats [$];
    t_result     pending_results [$];
    logic [7:0]  line_buf [$];

    bit          running;
    bit          s_took;
    bit          m_took;
    bit          hit;
    bit          calm;
    t_result     pred;
    t_result     want;
    t_beat       cur;
    int          stim_pos;
    int          s_gap;
    int          m_gap;
    int unsigned quiet;
    int unsigned err_cnt;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        if (err_cnt < 50)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void latch_fault(input t_status code);
        ln_phase    = PH_ERROR;
        latched_err = code;
        run_value   = '0;
    endfunction

    // one parse step; returns 1 when the beat yields a result
    function automatic bit parse_beat(input logic kind, input logic [CH_W-1:0] c,
                                      output t_result r);
        bit          emit;
        bit          blank;
        bit          digit;
        logic [19:0] acc;
        emit  = 1'b0;
        r     = '0;
        blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (kind == KIND_EOL) begin
            emit        = 1'b1;
            r.line_done = 1'b1;
            case (ln_phase)
                PH_START:  r.status = ST_EMPTY;
                PH_EXPECT: r.status = ST_TRAILING;
                PH_DIGITS: begin
                    r.status   = ST_OK;
                    r.id_valid = 1'b1;
                    r.id       = run_value;
                end
                PH_AFTER:  r.status = ST_OK;
                default:   r.status = latched_err;
            endcase
            ln_phase    = PH_START;
            run_value   = '0;
            latched_err = ST_OK;
        end else begin
            case (ln_phase)
                PH_START, PH_EXPECT: begin
                    if (digit) begin
                        ln_phase  = PH_DIGITS;
                        run_value = {8'b0, c - CH_ZERO};
                    end else if (!blank) begin
                        latch_fault(ST_NONNUM);
                    end
                end
                PH_DIGITS: begin
                    if (digit) begin
                        acc = {4'b0, run_value} * 20'd10 + {12'b0, c - CH_ZERO};
                        if (acc > ID_LIMIT)
                            latch_fault(ST_TOOLARGE);
                        else
                            run_value = acc[15:0];
                    end else begin
                        // run ends: id goes out on this beat
                        emit       = 1'b1;
                        r.id_valid = 1'b1;
                        r.id       = run_value;
                        run_value  = '0;
                        if (blank)
                            ln_phase = PH_AFTER;
                        else if (c == CH_COMMA)
                            ln_phase = PH_EXPECT;
                        else
                            latch_fault(ST_BADCHAR);
                    end
                end
                PH_AFTER: begin
                    if (c == CH_COMMA)
                        ln_phase = PH_EXPECT;
                    else if (!blank)
                        latch_fault(ST_BADCHAR);
                end
                default: ;
            endcase
        end
        return emit;
    endfunction

    // table rows
    function automatic t_beat plain(input logic [CH_W-1:0] c);
        t_beat b;
        b       = '0;
        b.kind  = KIND_CHAR;
        b.ch    = c;
        return b;
    endfunction

    function automatic t_beat emits(input logic [CH_W-1:0] c, input logic [15:0] id);
        t_beat b;
        b               = '0;
        b.kind          = KIND_CHAR;
        b.ch            = c;
        b.typed         = 1'b1;
        b.want.id_valid = 1'b1;
        b.want.id       = id;
        b.want.status   = ST_OK;
        return b;
    endfunction

    function automatic t_beat eol(input logic vld, input logic [15:0] id, input t_status st);
        t_beat b;
        b                = '0;
        b.kind           = KIND_EOL;
        b.typed          = 1'b1;
        b.want.id_valid  = vld;
        b.want.id        = id;
        b.want.line_done = 1'b1;
        b.want.status    = st;
        return b;
    endfunction

    task automatic queue_beat(input logic kind, input logic [CH_W-1:0] c);
        t_beat b;
        b      = '0;
        b.kind = kind;
        b.ch   = c;
        line_beats.insert(line_beats.size(), b);
    endtask

    // append one character to the line being built
    task automatic put_char(input logic [7:0] c);
        line_buf.insert(line_buf.size(), c);
    endtask

    task automatic add_blanks(input int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: put_char(CH_SPACE);
                1: put_char(CH_TAB);
                2: put_char(CH_CR);
                default: put_char(CH_LF);
            endcase
        end
    endtask

    // decimal digits of a value, sometimes with leading zeros or out of range
    task automatic add_number();
        int unsigned v;
        int          sel;
        int          nd;
        int          i;
        logic [7:0]  dg [0:9];
        sel = $urandom_range(0, 99);
        if (sel < 55)
            v = $urandom_range(0, 999);
        else if (sel < 75)
            v = $urandom_range(0, 65535);
        else if (sel < 87)
            v = $urandom_range(65525, 65535);
        else if (sel < 95)
            v = $urandom_range(65536, 99999);
        else
            v = $urandom_range(100000, 999999999);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) put_char(CH_ZERO);
        nd = 0;
        do begin
            dg[nd] = CH_ZERO + 8'(v % 10);
            v      = v / 10;
            nd++;
        end while (v != 0);
        for (i = nd - 1; i >= 0; i--)
            put_char(dg[i]);
    endtask

    // one random line: mostly well formed, some empty, broken or noise
    task automatic gen_line();
        int sel;
        int nf;
        int ek;
        int k;
        line_buf.delete();
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
            add_blanks(3);
        end else if (sel < 10) begin
            repeat ($urandom_range(1, 6)) put_char(8'($urandom_range(0, 255)));
        end else begin
            nf = $urandom_range(1, 6);
            ek = $urandom_range(0, nf - 1);
            for (k = 0; k < nf; k++) begin
                if (k > 0)
                    put_char(CH_COMMA);
                add_blanks(2);
                if (!(sel < 16 && k == ek))
                    add_number();
                add_blanks(2);
            end
            if (sel >= 16 && sel < 22)
                put_char(CH_COMMA);
            if (sel >= 22 && sel < 34)
                line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
        end
        for (k = 0; k < line_buf.size(); k++)
            queue_beat(KIND_CHAR, line_buf[k]);
        queue_beat(KIND_EOL, 8'($urandom_range(0, 255)));
    endtask

    // sample both channels, predict accepted beats, check results
    always @(posedge i_clk) begin
        if (running) begin
            s_took = i_s_tvalid && o_s_tready;
            m_took = o_m_tvalid && i_m_tready;
            if (s_took) begin
                cur = line_beats[stim_pos];
                hit = parse_beat(i_s_tuser, i_s_tdata, pred);
                if (cur.typed)
                    pending_results.insert(pending_results.size(), cur.want);
                else if (hit)
                    pending_results.insert(pending_results.size(), pred);
            end
            if (m_took) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result with nothing pending: id %0d last %0b",
                                            o_m_tdata[ID_W-1:0], o_m_tlast));
                end else begin
                    want = pending_results.pop_front();
                    if (o_m_tuser !== want.id_valid)
                        flag_mismatch($sformatf("id_valid got %0b want %0b",
                                                o_m_tuser, want.id_valid));
                    if (o_m_tdata[ID_W-1:0] !== want.id)
                        flag_mismatch($sformatf("id got %0d want %0d",
                                                o_m_tdata[ID_W-1:0], want.id));
                    if (o_m_tlast !== want.line_done)
                        flag_mismatch($sformatf("line_done got %0b want %0b",
                                                o_m_tlast, want.line_done));
                    if (o_m_tdata[ID_W+STATUS_W-1:ID_W] !== want.status)
                        flag_mismatch($sformatf("status got %0d want %0d",
                                                o_m_tdata[ID_W+STATUS_W-1:ID_W], want.status));
                end
            end
            if (s_took || m_took)
                quiet = 0;
            else
                quiet++;
        end
    end

    // drive beats and ready at the falling edge, with random idle bursts
    always @(negedge i_clk) begin
        if (running) begin
            if (s_took)
                stim_pos++;
            calm = (stim_pos + TAIL_N >= line_beats.size()) || ((stim_pos / 256) % 3 == 0);

            // slave side
            if (s_gap > 0) begin
                s_gap--;
            end else if (!i_s_tvalid || s_took) begin
                if (stim_pos >= line_beats.size()) begin
                    i_s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 11) == 0) begin
                    s_gap = $urandom_range(0, 18);
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= line_beats[stim_pos].kind;
                    i_s_tdata  <= line_beats[stim_pos].ch;
                end
            end

            // master side
            if (m_gap > 0) begin
                m_gap--;
                i_m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                m_gap = $urandom_range(0, 18);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int i;
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = KIND_CHAR;
        i_m_tready  = 1'b0;
        running     = 1'b0;
        s_took      = 1'b0;
        m_took      = 1'b0;
        stim_pos    = 0;
        s_gap       = 0;
        m_gap       = 0;
        quiet       = 0;
        err_cnt     = 0;
        ln_phase    = PH_START;
        run_value   = '0;
        latched_err = ST_OK;

        // directed lines: empty, blanks and trailing comma, max id, overflow,
        // leading comma, bad char ending a run, digit after an id and a space
        dir_tab = '{
            eol(1'b0, 16'd0, ST_EMPTY),
            plain(CH_SPACE),
            plain(CH_ZERO),
            emits(CH_TAB, 16'd0),
            plain(CH_COMMA),
            plain(CH_CR),
            plain(CH_LF),
            eol(1'b0, 16'd0, ST_TRAILING),
            plain(CH_ZERO + 8'd6),
            plain(CH_ZERO + 8'd5),
            plain(CH_ZERO + 8'd5),
            plain(CH_ZERO + 8'd3),
            plain(CH_ZERO + 8'd5),
            eol(1'b1, 16'd65535, ST_OK),
            plain(CH_ZERO + 8'd6),
            plain(CH_ZERO + 8'd5),
            plain(CH_ZERO + 8'd5),
            plain(CH_ZERO + 8'd3),
            plain(CH_ZERO + 8'd6),
            eol(1'b0, 16'd0, ST_TOOLARGE),
            plain(CH_COMMA),
            eol(1'b0, 16'd0, ST_NONNUM),
            plain(CH_ZERO + 8'd7),
            emits(8'hff, 16'd7),
            eol(1'b0, 16'd0, ST_BADCHAR),
            plain(CH_ZERO + 8'd1),
            emits(CH_SPACE, 16'd1),
            plain(CH_ZERO + 8'd2),
            eol(1'b0, 16'd0, ST_BADCHAR)
        };
        for (i = 0; i < DIR_N; i++)
            line_beats.insert(line_beats.size(), dir_tab[i]);
        while (line_beats.size() < DIR_N + RAND_ITEMS)
            gen_line();

        // reset, released at a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1'b1;

        while (!(stim_pos >= line_beats.size() && pending_results.size() == 0)
               && quiet < QUIET_LIMIT)
            @(posedge i_clk);

        if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            repeat (8) @(posedge i_clk);
            if (err_cnt == 0)
                $display("tb OK");
            else
                $display("tb NOT OK");
            $finish;
        end
    end

endmodule
